// ===== hw/rtl/pswt_pkg.sv =====
package pswt_pkg;

    // Capacity of the process store by default.
    localparam int DEF_MAX_PROCESSES = 16;

    // Field widths of a request and of a result.
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int NUM_W   = 7;
    localparam int TIME_W  = 22;
    localparam int AVG_W   = 30;
    localparam int FRAC_W  = 8;

    // One stored process: arrival number, priority and burst.
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

endpackage

// ===== hw/rtl/pswt_ram.sv =====
module pswt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pswt_div.sv =====
module pswt_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             r_run;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        w_sh   = {r_rem, r_quo[DVD_W-1]};
        w_ge   = (w_sh >= {1'b0, i_divisor});
        w_diff = w_sh - {1'b0, i_divisor};
    end

    // Sequencing of the bit steps; the divisor is held steady by the caller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/priority_schedule_wait_times_top.sv =====
// Non-preemptive priority scheduler. Processes are loaded one request per
// cycle while busy is low; each is numbered from 1 in arrival order, and
// arrivals beyond MAX_PROCESSES are dropped and flagged. The request with
// closes_batch set raises busy, and the batch of n held processes is then
// ordered by falling priority with an exchange sort that walks one RAM port.
// Results follow, one per cycle, for the first n-1 processes; the last
// result waits for two averages from a shared bit-serial divider. The
// running totals are 30 bits wide at the largest capacity, 26 at the default.
// Each result is on the ports for one cycle, marked by o_strobe, and must be
// taken then: the receiver cannot stall. busy falls after the final result.
module priority_schedule_wait_times_top #(
    parameter int MAX_PROCESSES = pswt_pkg::DEF_MAX_PROCESSES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pswt_pkg::BURST_W-1:0]  i_burst_length,
    input  logic [pswt_pkg::PRIO_W-1:0]   i_priority_level,
    input  logic                          i_closes_batch,
    output logic                          o_strobe,
    output logic [pswt_pkg::NUM_W-1:0]    o_process_number,
    output logic [pswt_pkg::BURST_W-1:0]  o_burst_echo,
    output logic [pswt_pkg::PRIO_W-1:0]   o_priority_echo,
    output logic [pswt_pkg::TIME_W-1:0]   o_wait_time,
    output logic [pswt_pkg::TIME_W-1:0]   o_turnaround,
    output logic [pswt_pkg::AVG_W-1:0]    o_average_wait,
    output logic [pswt_pkg::AVG_W-1:0]    o_average_turnaround,
    output logic                          o_dropped_some,
    output logic                          o_final_result
);
    localparam int AW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int WAIT_W = pswt_pkg::BURST_W + CNT_W;
    localparam int TOT_W  = WAIT_W + CNT_W;
    localparam int DVD_W  = TOT_W + pswt_pkg::FRAC_W;
    localparam int ENT_W  = $bits(pswt_pkg::t_entry);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD_I  = 4'd1;
    localparam logic [3:0] S_TAKE_I  = 4'd2;
    localparam logic [3:0] S_CMP     = 4'd3;
    localparam logic [3:0] S_PUT_I   = 4'd4;
    localparam logic [3:0] S_EM_RD   = 4'd5;
    localparam logic [3:0] S_EM_OUT  = 4'd6;
    localparam logic [3:0] S_DIVW_GO = 4'd7;
    localparam logic [3:0] S_DIVW    = 4'd8;
    localparam logic [3:0] S_DIVT_GO = 4'd9;
    localparam logic [3:0] S_DIVT    = 4'd10;
    localparam logic [3:0] S_FINAL   = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_overflow, n_overflow;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_k, n_k;
    pswt_pkg::t_entry  r_hold, n_hold;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [TOT_W-1:0]  r_tot_w, n_tot_w;
    logic [TOT_W-1:0]  r_tot_t, n_tot_t;
    logic [DVD_W-1:0]  r_avg_w, n_avg_w;

    logic              w_accept;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    pswt_pkg::t_entry  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [ENT_W-1:0]  w_rdata_raw;
    pswt_pkg::t_entry  w_rdata;
    pswt_pkg::t_entry  w_sel;
    logic [CNT_W-1:0]  w_last_idx;
    logic [CNT_W-1:0]  w_j_inc;
    logic [CNT_W-1:0]  w_k_inc;
    logic [WAIT_W-1:0] w_turn;
    logic [WAIT_W-1:0] w_sel_turn;
    logic              w_em_last;
    logic              w_div_start;
    logic [DVD_W-1:0]  w_div_dvd;
    logic              w_div_done;
    logic [DVD_W-1:0]  w_div_quo;

    assign w_accept   = start && !busy;
    assign w_rdata    = pswt_pkg::t_entry'(w_rdata_raw);
    assign w_last_idx = r_count - CNT_W'(1);
    assign w_j_inc    = r_j + CNT_W'(1);
    assign w_k_inc    = r_k + CNT_W'(1);
    assign w_turn     = r_wait + WAIT_W'(w_rdata.burst);
    assign w_em_last  = (r_k == w_last_idx);

    // Process store, one entry per slot.
    pswt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PROCESSES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // Shared divider for both averages; the divisor is the batch size.
    pswt_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Sequencer: loading, exchange sort, emission and the two divisions.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_hold      = r_hold;
        n_wait      = r_wait;
        n_tot_w     = r_tot_w;
        n_tot_t     = r_tot_t;
        n_avg_w     = r_avg_w;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = r_hold;
        w_raddr     = r_i[AW-1:0];
        w_div_start = 1'b0;
        w_div_dvd   = {r_tot_w, pswt_pkg::FRAC_W'(0)};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_count < CNT_W'(MAX_PROCESSES)) begin
                        w_we          = 1'b1;
                        w_waddr       = r_count[AW-1:0];
                        w_wdata.num   = pswt_pkg::NUM_W'(r_count + CNT_W'(1));
                        w_wdata.prio  = i_priority_level;
                        w_wdata.burst = i_burst_length;
                        n_count       = r_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_closes_batch) begin
                        n_i     = '0;
                        n_state = (n_count < CNT_W'(2)) ? S_EM_RD : S_LOAD_I;
                    end
                end
            end
            S_LOAD_I: begin
                w_raddr = r_i[AW-1:0];
                n_j     = r_i + CNT_W'(1);
                n_state = S_TAKE_I;
            end
            S_TAKE_I: begin
                w_raddr = r_j[AW-1:0];
                n_hold  = w_rdata;
                n_state = S_CMP;
            end
            S_CMP: begin
                // Slot i lives in r_hold; swap it with slot j on a higher priority.
                w_raddr = w_j_inc[AW-1:0];
                if (r_hold.prio < w_rdata.prio) begin
                    w_we    = 1'b1;
                    w_waddr = r_j[AW-1:0];
                    w_wdata = r_hold;
                    n_hold  = w_rdata;
                end
                if (r_j == w_last_idx) begin
                    n_state = S_PUT_I;
                end else begin
                    n_j = w_j_inc;
                end
            end
            S_PUT_I: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_hold;
                if (r_i + CNT_W'(2) == r_count) begin
                    n_state = S_EM_RD;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_LOAD_I;
                end
            end
            S_EM_RD: begin
                w_raddr = '0;
                n_k     = '0;
                n_wait  = '0;
                n_tot_w = '0;
                n_tot_t = '0;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                w_raddr = w_k_inc[AW-1:0];
                n_tot_w = r_tot_w + TOT_W'(r_wait);
                n_tot_t = r_tot_t + TOT_W'(w_turn);
                if (w_em_last) begin
                    n_hold  = w_rdata;
                    n_state = S_DIVW_GO;
                end else begin
                    n_wait = w_turn;
                    n_k    = w_k_inc;
                end
            end
            S_DIVW_GO: begin
                w_div_start = 1'b1;
                w_div_dvd   = {r_tot_w, pswt_pkg::FRAC_W'(0)};
                n_state     = S_DIVW;
            end
            S_DIVW: begin
                if (w_div_done) begin
                    n_avg_w = w_div_quo;
                    n_state = S_DIVT_GO;
                end
            end
            S_DIVT_GO: begin
                w_div_start = 1'b1;
                w_div_dvd   = {r_tot_t, pswt_pkg::FRAC_W'(0)};
                n_state     = S_DIVT;
            end
            S_DIVT: begin
                if (w_div_done) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_count    = '0;
                n_overflow = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    // Working registers of the sort and emission.
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_hold  <= n_hold;
        r_wait  <= n_wait;
        r_tot_w <= n_tot_w;
        r_tot_t <= n_tot_t;
        r_avg_w <= n_avg_w;
    end

    // Result ports: straight from the store while streaming, from r_hold at the end.
    always_comb begin
        w_sel      = (r_state == S_FINAL) ? r_hold : w_rdata;
        w_sel_turn = r_wait + WAIT_W'(w_sel.burst);
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_strobe             = ((r_state == S_EM_OUT) && !w_em_last) ||
                                  (r_state == S_FINAL);
    assign o_process_number     = w_sel.num;
    assign o_burst_echo         = w_sel.burst;
    assign o_priority_echo      = w_sel.prio;
    assign o_wait_time          = pswt_pkg::TIME_W'(r_wait);
    assign o_turnaround         = pswt_pkg::TIME_W'(w_sel_turn);
    assign o_average_wait       = (r_state == S_FINAL) ?
                                  pswt_pkg::AVG_W'(r_avg_w) : '0;
    assign o_average_turnaround = (r_state == S_FINAL) ?
                                  pswt_pkg::AVG_W'(w_div_quo) : '0;
    assign o_dropped_some       = r_overflow;
    assign o_final_result       = (r_state == S_FINAL);

`ifndef SYNTHESIS
    // Results appear only while a batch is being scheduled.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // A request that does not close the batch leaves the block ready.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_closes_batch) |=> !busy)
        else $error("busy after a loading request");

    // The final result ends the batch.
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_result) |=> (!busy && r_count == '0 && !r_overflow))
        else $error("batch state not cleared after final result");

    // The store never holds more than its capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCESSES))
        else $error("process count beyond capacity");
`endif

endmodule

// ===== tb/priority_schedule_wait_times_top_test.sv =====
`timescale 1ns / 1ps

module priority_schedule_wait_times_top_test;

    import pswt_pkg::*;

    localparam int CAPACITY      = DEF_MAX_PROCESSES;
    // Worst batch: full exchange sort, emission and the two serial divisions.
    localparam int SETTLE_CYCLES = 400;

    // One expected line of the schedule, in emission order.
    typedef struct {
        logic [NUM_W-1:0]   num;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  wait_t;
        logic [TIME_W-1:0]  turn_t;
        logic [AVG_W-1:0]   avg_wait;
        logic [AVG_W-1:0]   avg_turn;
        logic               dropped;
        logic               last_line;
    } t_schedule_line;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [BURST_W-1:0]   i_burst_length;
    logic [PRIO_W-1:0]    i_priority_level;
    logic                 i_closes_batch;
    logic                 o_strobe;
    logic [NUM_W-1:0]     o_process_number;
    logic [BURST_W-1:0]   o_burst_echo;
    logic [PRIO_W-1:0]    o_priority_echo;
    logic [TIME_W-1:0]    o_wait_time;
    logic [TIME_W-1:0]    o_turnaround;
    logic [AVG_W-1:0]     o_average_wait;
    logic [AVG_W-1:0]     o_average_turnaround;
    logic                 o_dropped_some;
    logic                 o_final_result;

    // Shadow copy of the process store held by the predictor.
    t_entry               held_procs [CAPACITY];
    int                   held_count;
    bit                   held_overflow;

    t_schedule_line       schedule_q [$];

    int                   sender_idle_pct;
    int                   requests_sent;
    int                   requests_taken;
    int                   batches_closed;
    int                   overflow_batches;
    int                   lines_checked;
    int                   mismatches;

    priority_schedule_wait_times_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_burst_length       (i_burst_length),
        .i_priority_level     (i_priority_level),
        .i_closes_batch       (i_closes_batch),
        .o_strobe             (o_strobe),
        .o_process_number     (o_process_number),
        .o_burst_echo         (o_burst_echo),
        .o_priority_echo      (o_priority_echo),
        .o_wait_time          (o_wait_time),
        .o_turnaround         (o_turnaround),
        .o_average_wait       (o_average_wait),
        .o_average_turnaround (o_average_turnaround),
        .o_dropped_some       (o_dropped_some),
        .o_final_result       (o_final_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stores one arriving process and, when it closes the batch, queues the schedule.
    task automatic schedule_request(input logic [BURST_W-1:0] burst,
                                    input logic [PRIO_W-1:0] prio, input logic closes);
        t_entry         tmp;
        t_schedule_line line;
        logic [63:0]    run_wait;
        logic [63:0]    run_turn;
        logic [63:0]    sum_wait;
        logic [63:0]    sum_turn;
        int             i;
        int             j;
        if (held_count < CAPACITY) begin
            held_procs[held_count] = '{num: NUM_W'(held_count + 1), prio: prio, burst: burst};
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!closes) return;

        batches_closed++;
        if (held_overflow) overflow_batches++;
        if (held_count == 0) begin
            held_overflow = 1'b0;
            return;
        end

        // Exchange sort by falling priority; ties land where this sort puts them.
        for (i = 0; i + 1 < held_count; i++) begin
            for (j = i + 1; j < held_count; j++) begin
                if (held_procs[i].prio < held_procs[j].prio) begin
                    tmp           = held_procs[i];
                    held_procs[i] = held_procs[j];
                    held_procs[j] = tmp;
                end
            end
        end

        // Waiting time is the running sum of the bursts served so far.
        run_wait = '0;
        sum_wait = '0;
        sum_turn = '0;
        for (i = 0; i < held_count; i++) begin
            run_turn       = run_wait + held_procs[i].burst;
            sum_wait       = sum_wait + run_wait;
            sum_turn       = sum_turn + run_turn;
            line.num       = held_procs[i].num;
            line.burst     = held_procs[i].burst;
            line.prio      = held_procs[i].prio;
            line.wait_t    = run_wait[TIME_W-1:0];
            line.turn_t    = run_turn[TIME_W-1:0];
            line.dropped   = held_overflow;
            line.last_line = (i == held_count - 1);
            line.avg_wait  = '0;
            line.avg_turn  = '0;
            if (line.last_line) begin
                line.avg_wait = AVG_W'((sum_wait << FRAC_W) / held_count);
                line.avg_turn = AVG_W'((sum_turn << FRAC_W) / held_count);
            end
            schedule_q.push_back(line);
            run_wait = run_turn;
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endtask

    function automatic void compare_field(input string name, input logic [63:0] exp_val,
                                          input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Checks each result against the oldest expected line, then records new requests.
    always @(posedge i_clk) begin : scoreboard
        t_schedule_line exp_line;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (schedule_q.size() == 0) begin
                    $error("Result with nothing expected: process %0d", o_process_number);
                    mismatches++;
                end else begin
                    exp_line = schedule_q.pop_front();
                    compare_field("process_number", exp_line.num, o_process_number);
                    compare_field("burst_echo", exp_line.burst, o_burst_echo);
                    compare_field("priority_echo", exp_line.prio, o_priority_echo);
                    compare_field("wait_time", exp_line.wait_t, o_wait_time);
                    compare_field("turnaround", exp_line.turn_t, o_turnaround);
                    compare_field("average_wait", exp_line.avg_wait, o_average_wait);
                    compare_field("average_turnaround", exp_line.avg_turn,
                                  o_average_turnaround);
                    compare_field("dropped_some", exp_line.dropped, o_dropped_some);
                    compare_field("final_result", exp_line.last_line, o_final_result);
                    lines_checked++;
                end
            end
            if (start && !busy) begin
                requests_taken++;
                schedule_request(i_burst_length, i_priority_level, i_closes_batch);
            end
        end
    end

    // Presents one request, holds it until taken, then may idle with start low and random fields.
    task automatic send_request(input logic [BURST_W-1:0] burst,
                                input logic [PRIO_W-1:0] prio, input logic closes);
        start            <= 1'b1;
        i_burst_length   <= burst;
        i_priority_level <= prio;
        i_closes_batch   <= closes;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        while ($urandom_range(99) < sender_idle_pct) begin
            start            <= 1'b0;
            i_burst_length   <= BURST_W'($urandom);
            i_priority_level <= PRIO_W'($urandom);
            i_closes_batch   <= 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // A batch of one process at the field extremes, then one at the other end.
    task automatic test_single_process();
        send_request('1, '0, 1'b1);
        send_request('0, '1, 1'b1);
    endtask

    // Equal priorities: the order comes from the exchange sort alone.
    task automatic test_tied_priorities();
        send_request(16'd0, 8'h80, 1'b0);
        send_request(16'd1, 8'h80, 1'b0);
        send_request('1, 8'h80, 1'b1);
    endtask

    // Rising priorities force the sort to reverse the arrival order.
    task automatic test_reverse_order();
        send_request(16'd100, 8'd0, 1'b0);
        send_request(16'd200, 8'd1, 1'b0);
        send_request(16'd300, 8'd2, 1'b0);
        send_request(16'd400, 8'hFF, 1'b1);
    endtask

    // A full store of maximum bursts, then a closing request that is dropped.
    task automatic test_full_store_overflow();
        int k;
        for (k = 0; k < CAPACITY; k++) begin
            send_request('1, PRIO_W'($urandom_range(0, 3)), 1'b0);
        end
        send_request(BURST_W'($urandom), PRIO_W'($urandom), 1'b1);
    endtask

    // Random batches, mostly small, some filling or overflowing the store.
    task automatic test_random_batches(input int target);
        int sent;
        int size;
        int pick;
        int prio_mode;
        int k;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) size = $urandom_range(1, 6);
            else if (pick < 90) size = $urandom_range(7, CAPACITY);
            else size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            prio_mode = $urandom_range(3);
            for (k = 0; k < size; k++) begin
                pick = $urandom_range(99);
                if (pick < 10) burst = '0;
                else if (pick < 20) burst = '1;
                else burst = BURST_W'($urandom);
                case (prio_mode)
                    0: prio = 8'h5A;
                    1: prio = PRIO_W'($urandom_range(0, 3));
                    2: prio = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                    default: prio = PRIO_W'($urandom);
                endcase
                send_request(burst, prio, k == size - 1);
                sent++;
            end
        end
    endtask

    initial begin
        start            = 1'b0;
        i_burst_length   = '0;
        i_priority_level = '0;
        i_closes_batch   = 1'b0;
        i_rst_n          = 1'b0;
        held_count       = 0;
        held_overflow    = 1'b0;
        sender_idle_pct  = 19;
        requests_sent    = 0;
        requests_taken   = 0;
        batches_closed   = 0;
        overflow_batches = 0;
        lines_checked    = 0;
        mismatches       = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_process();
        test_tied_priorities();
        test_reverse_order();
        test_full_store_overflow();
        test_random_batches(40);
        sender_idle_pct = 57;
        test_random_batches(40);
        sender_idle_pct = 0;
        test_random_batches(40);
        start <= 1'b0;

        // Drain the remaining schedule lines, then watch for stray results.
        while (schedule_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (schedule_q.size() != 0) begin
            $error("%0d expected results never arrived", schedule_q.size());
            mismatches++;
        end
        $display("Ran %0d requests in %0d batches, %0d of them with dropped arrivals.",
                 requests_taken, batches_closed, overflow_batches);
        $display("Checked %0d schedule lines with sender idle rates of 19, 57 and 0 percent.",
                 lines_checked);
        if (mismatches == 0) begin
            $display("priority_schedule_wait_times_top_test OK");
        end else begin
            $display("priority_schedule_wait_times_top_test NOT OK");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5ms;
        $display("Timeout with %0d results still expected.", schedule_q.size());
        $display("priority_schedule_wait_times_top_test NOT OK");
        $finish;
    end

endmodule
